// ===== rtl/cdq_pkg.sv =====
// Package: shared types and constants of the circular deque unit.
package cdq_pkg;

  localparam int unsigned DEPTH  = 16;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned OCC_W  = 5;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    OP_PUSH_REAR  = 2'd0,
    OP_PUSH_FRONT = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } cdq_op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } cdq_status_e;

  // Broadcast to every cell of the row.
  typedef struct packed {
    logic    en;
    cdq_op_e op;
  } cdq_ctrl_t;

endpackage

// ===== rtl/cdq_if.sv =====
// Interfaces: operation channel and result channel of the circular deque unit.
interface cdq_in_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               func;
  logic signed [cdq_pkg::WORD_W-1:0] data_in;

  modport source (output valid, func, data_in, input ready);
  modport sink   (input valid, func, data_in, output ready);
endinterface

interface cdq_out_if;
  logic                     valid;
  logic                     ready;
  logic signed [cdq_pkg::WORD_W-1:0] data_out;
  logic [1:0]               status;
  logic [cdq_pkg::OCC_W-1:0] occupancy;

  modport source (output valid, data_out, status, occupancy, input ready);
  modport sink   (input valid, data_out, status, occupancy, output ready);
endinterface

// ===== rtl/cdq_cell.sv =====
// Cell: one slot of the deque row, shifting with its neighbors.
module cdq_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  cdq_pkg::cdq_ctrl_t           ctrl_i,
  input  logic [cdq_pkg::WORD_W-1:0]   din_i,
  input  logic                         left_occ_i,
  input  logic [cdq_pkg::WORD_W-1:0]   left_data_i,
  input  logic                         right_occ_i,
  input  logic [cdq_pkg::WORD_W-1:0]   right_data_i,
  output logic                         occ_o,
  output logic [cdq_pkg::WORD_W-1:0]   data_o
);

  logic                       occ_q, occ_d;
  logic [cdq_pkg::WORD_W-1:0] data_q, data_d;

  always_comb begin
    occ_d  = occ_q;
    data_d = data_q;
    if (ctrl_i.en) begin
      case (ctrl_i.op)
        cdq_pkg::OP_PUSH_REAR: begin
          // fill the first free slot
          if (!occ_q && left_occ_i) begin
            occ_d  = 1'b1;
            data_d = din_i;
          end
        end
        cdq_pkg::OP_PUSH_FRONT: begin
          occ_d  = left_occ_i;
          data_d = left_data_i;
        end
        cdq_pkg::OP_POP_FRONT: begin
          occ_d  = right_occ_i;
          data_d = right_data_i;
        end
        cdq_pkg::OP_POP_REAR: begin
          // drop the last occupied slot
          if (occ_q && !right_occ_i) occ_d = 1'b0;
        end
        default: begin
          occ_d  = occ_q;
          data_d = data_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign occ_o  = occ_q;
  assign data_o = data_q;

endmodule

// ===== rtl/circular_deque_unit.sv =====
// Top level: double-ended queue built as a row of shifting cells.
// The deque holds up to DEPTH (16) signed 32-bit words in a row of cells, with
// cell 0 always the front word and the occupied cells forming one unbroken run
// from cell 0. Each transaction on in_i carries an operation (push rear, push
// front, pop front, pop rear) and a word; exactly one result transaction on
// out_o follows, giving the popped word (zero otherwise), a status (done,
// overflow on a push into a full deque, underflow on a pop from an empty one)
// and the word count after the operation. A failed operation changes nothing.
// Throughput is one operation per clock while results are taken: a push or a pop
// at the front shifts the whole row by one cell, a push at the rear fills the
// first free cell, and a pop at the rear frees the last occupied one.
// The result is registered and appears the cycle after acceptance; the result
// register is the only buffer, so a new operation is taken in the same cycle
// that the pending result is taken, or whenever no result is pending.
// Word storage has no reset; only the occupancy bits, the count and the result-valid flag are cleared.
module circular_deque_unit (
  input  logic      clk_i,
  input  logic      rst_ni,
  cdq_in_if.sink    in_i,
  cdq_out_if.source out_o
);

  localparam int unsigned Depth = cdq_pkg::DEPTH;
  localparam int unsigned WordW = cdq_pkg::WORD_W;
  localparam int unsigned CntW  = cdq_pkg::CNT_W;
  localparam int unsigned OccW  = cdq_pkg::OCC_W;

  logic                 out_valid_q;
  logic [WordW-1:0]     out_data_q, out_data_d;
  cdq_pkg::cdq_status_e out_status_q, out_status_d;
  logic [OccW-1:0]      out_occ_q;

  logic [CntW-1:0]      count_q, count_d;
  logic                 accept;
  logic                 full;
  logic                 empty;
  cdq_pkg::cdq_op_e     op;
  cdq_pkg::cdq_ctrl_t   ctrl;

  logic [Depth-1:0]             occ_vec;
  logic [Depth-1:0][WordW-1:0]  data_vec;
  logic [WordW-1:0]             rear_word;

  // Take a new operation whenever the result slot is free or draining.
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign op    = cdq_pkg::cdq_op_e'(in_i.func);
  assign full  = (count_q == CntW'(Depth));
  assign empty = (count_q == '0);

  // Decide status, popped word and new count; enable the row only on success.
  always_comb begin
    out_status_d = cdq_pkg::ST_DONE;
    out_data_d   = '0;
    count_d      = count_q;
    case (op)
      cdq_pkg::OP_PUSH_REAR, cdq_pkg::OP_PUSH_FRONT: begin
        if (full) begin
          out_status_d = cdq_pkg::ST_OVERFLOW;
        end else begin
          count_d = count_q + CntW'(1);
        end
      end
      cdq_pkg::OP_POP_FRONT: begin
        if (empty) begin
          out_status_d = cdq_pkg::ST_UNDERFLOW;
        end else begin
          out_data_d = data_vec[0];
          count_d    = count_q - CntW'(1);
        end
      end
      cdq_pkg::OP_POP_REAR: begin
        if (empty) begin
          out_status_d = cdq_pkg::ST_UNDERFLOW;
        end else begin
          out_data_d = rear_word;
          count_d    = count_q - CntW'(1);
        end
      end
      default: begin
        out_status_d = cdq_pkg::ST_DONE;
      end
    endcase
  end

  assign ctrl.op = op;
  assign ctrl.en = accept && (out_status_d == cdq_pkg::ST_DONE);

  // Pick the rear word: the one occupied cell whose right neighbor is free.
  always_comb begin
    rear_word = '0;
    for (int i = 0; i < Depth; i++) begin
      if (occ_vec[i] && ((i == Depth - 1) || !occ_vec[(i + 1) % Depth])) begin
        rear_word = rear_word | data_vec[i];
      end
    end
  end

  // Row of cells: left edge feeds the pushed word, right edge feeds an empty slot.
  for (genvar g = 0; g < Depth; g++) begin : g_cell
    logic             left_occ;
    logic [WordW-1:0] left_data;
    logic             right_occ;
    logic [WordW-1:0] right_data;

    if (g == 0) begin : g_left_edge
      assign left_occ  = 1'b1;
      assign left_data = in_i.data_in;
    end else begin : g_left_inner
      assign left_occ  = occ_vec[g-1];
      assign left_data = data_vec[g-1];
    end

    if (g == Depth - 1) begin : g_right_edge
      assign right_occ  = 1'b0;
      assign right_data = '0;
    end else begin : g_right_inner
      assign right_occ  = occ_vec[g+1];
      assign right_data = data_vec[g+1];
    end

    cdq_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .din_i        (in_i.data_in),
      .left_occ_i   (left_occ),
      .left_data_i  (left_data),
      .right_occ_i  (right_occ),
      .right_data_i (right_data),
      .occ_o        (occ_vec[g]),
      .data_o       (data_vec[g])
    );
  end

  // Control state: word count and result-valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload: load on accept, hold while stalled.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q   <= out_data_d;
      out_status_q <= out_status_d;
      out_occ_q    <= OccW'(count_d);
    end
  end

  assign out_o.valid     = out_valid_q;
  assign out_o.data_out  = out_data_q;
  assign out_o.status    = out_status_q;
  assign out_o.occupancy = out_occ_q;

  // Checks on the cell row and the result path.
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("word count beyond deque depth");

  a_occ_matches_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(occ_vec) == int'(count_q))
    else $error("occupied cells disagree with word count");

  a_occ_contiguous: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((occ_vec & (occ_vec - Depth'(1))) == '0) || (occ_vec[0] &&
      (((occ_vec + Depth'(1)) & occ_vec) == '0)))
    else $error("occupied cells not a run from the front");

  a_overflow_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == cdq_pkg::ST_OVERFLOW) |->
      (out_occ_q == OccW'(Depth)) && (out_data_q == '0))
    else $error("overflow reported with deque not full");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_status_q == cdq_pkg::ST_UNDERFLOW) |->
      (out_occ_q == '0) && (out_data_q == '0))
    else $error("underflow reported with deque not empty");

endmodule

// ===== test/cdq_checker.sv =====
// Checker: predicts deque results from accepted operations and compares them.
module cdq_checker
  import cdq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  cdq_in_if           op_mon,
  cdq_out_if          res_mon,
  output int unsigned fail_cnt_o,
  output int unsigned owed_cnt_o
);

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [WORD_W-1:0] data;
    cdq_status_e              status;
    logic [OCC_W-1:0]         occ;
  } deque_result_t;

  // Predicted deque contents: ring of words with front and rear indices.
  logic [WORD_W-1:0] ring_mdl [DEPTH];
  int unsigned       head_mdl;
  int unsigned       tail_mdl;
  int unsigned       fill_mdl;
  deque_result_t     owed_results_q [$];
  int unsigned       mismatch_cnt;

  function automatic int unsigned wrap_next(input int unsigned idx);
    return (idx == DEPTH - 1) ? 0 : idx + 1;
  endfunction

  function automatic int unsigned wrap_prev(input int unsigned idx);
    return (idx == 0) ? DEPTH - 1 : idx - 1;
  endfunction

  // Apply one operation to the predicted deque and return its result.
  function automatic deque_result_t apply_deque_op(input cdq_op_e op,
                                                   input logic [WORD_W-1:0] word);
    deque_result_t r;
    r.data   = '0;
    r.status = ST_DONE;
    case (op)
      OP_PUSH_REAR, OP_PUSH_FRONT: begin
        if (fill_mdl >= DEPTH) begin
          r.status = ST_OVERFLOW;
        end else if (op == OP_PUSH_REAR) begin
          ring_mdl[tail_mdl] = word;
          tail_mdl = wrap_next(tail_mdl);
          fill_mdl++;
        end else begin
          head_mdl = wrap_prev(head_mdl);
          ring_mdl[head_mdl] = word;
          fill_mdl++;
        end
      end
      default: begin
        if (fill_mdl == 0) begin
          r.status = ST_UNDERFLOW;
        end else if (op == OP_POP_FRONT) begin
          r.data = ring_mdl[head_mdl];
          head_mdl = wrap_next(head_mdl);
          fill_mdl--;
        end else begin
          tail_mdl = wrap_prev(tail_mdl);
          r.data = ring_mdl[tail_mdl];
          fill_mdl--;
        end
      end
    endcase
    r.occ = OCC_W'(fill_mdl);
    return r;
  endfunction

  task automatic report_failure(input string what);
    if (mismatch_cnt < MAX_REPORTS) begin
      $display("%s", what);
    end
    mismatch_cnt++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    deque_result_t exp_r;
    if (!rst_ni) begin
      head_mdl     = 0;
      tail_mdl     = 0;
      fill_mdl     = 0;
      mismatch_cnt = 0;
      owed_results_q.delete();
      fail_cnt_o <= 0;
      owed_cnt_o <= 0;
    end else begin
      // Predict first, so the queue always holds every accepted operation.
      if (op_mon.valid && op_mon.ready) begin
        owed_results_q.push_back(apply_deque_op(cdq_op_e'(op_mon.func),
                                                op_mon.data_in));
      end
      if (res_mon.valid && res_mon.ready) begin
        if (owed_results_q.size() == 0) begin
          report_failure($sformatf("unexpected result: data %0d status %0d occ %0d",
                                   res_mon.data_out, res_mon.status,
                                   res_mon.occupancy));
        end else begin
          exp_r = owed_results_q.pop_front();
          if (res_mon.data_out !== exp_r.data || res_mon.status !== exp_r.status ||
              res_mon.occupancy !== exp_r.occ) begin
            report_failure($sformatf(
              "result mismatch: expected data %0d status %0d occ %0d, got %0d %0d %0d",
              exp_r.data, exp_r.status, exp_r.occ,
              res_mon.data_out, res_mon.status, res_mon.occupancy));
          end
        end
      end
      fail_cnt_o <= mismatch_cnt;
      owed_cnt_o <= owed_results_q.size();
    end
  end

endmodule

// ===== test/tb_circular_deque_unit.sv =====
// Testbench top: drives deque operations, paces the result side, gives the verdict.
module tb_circular_deque_unit;
  import cdq_pkg::*;

  localparam int unsigned RESET_CYCLES   = 7;
  localparam int unsigned RANDOM_ITEMS   = 1080;
  localparam int unsigned HOLD_AT        = 400;   // item index where the long stall starts
  localparam int unsigned PAUSE_AT       = 700;   // item index where the sender drains
  localparam int unsigned QUIET_AT       = 950;   // no idling on either side from here
  localparam int unsigned LONG_HOLD      = 60;
  localparam int unsigned DRAIN_CYCLES   = 20;
  // Longest correct gap between transactions is the long stall plus one burst;
  // take it many times over.
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic        clk;
  logic        rst_n;
  logic        long_hold_req;
  logic        quiet_end;
  int unsigned fail_cnt;
  int unsigned owed_cnt;
  int unsigned stuck_cycles;

  cdq_in_if  in_if ();
  cdq_out_if out_if ();

  circular_deque_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  cdq_checker u_checker (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .op_mon     (in_if),
    .res_mon    (out_if),
    .fail_cnt_o (fail_cnt),
    .owed_cnt_o (owed_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Pick a push word: mostly random, sometimes zero, all ones or one of the signed extremes.
  function automatic logic [WORD_W-1:0] pick_word(input bit edge_only);
    logic [WORD_W-1:0] w;
    w = $urandom;
    if (edge_only || $urandom_range(0, 7) == 0) begin
      case ($urandom_range(0, 3))
        0:       w = 32'h0000_0000;
        1:       w = 32'hFFFF_FFFF;
        2:       w = 32'h7FFF_FFFF;
        default: w = 32'h8000_0000;
      endcase
    end
    return w;
  endfunction

  // Offer one operation and return at the edge where the transaction happens.
  // Valid is left high so a following call keeps the stream back to back.
  task automatic send_op(input cdq_op_e op, input logic [WORD_W-1:0] word);
    in_if.valid   <= 1'b1;
    in_if.func    <= op;
    in_if.data_in <= word;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Drop valid and hold until every owed result has been taken.
  task automatic drain_results();
    in_if.valid <= 1'b0;
    do @(posedge clk); while (owed_cnt != 0);
  endtask

  // Result side: random stall bursts, ready stretches, one long hold-off on
  // request, and steady ready once the quiet tail starts.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_if.ready <= 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (long_hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if (!quiet_end && $urandom_range(0, 3) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk);
      end
    end
  end

  // Watchdog: end the run if no transaction moves on either channel for too long.
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned push_bias;
    int unsigned epoch_left;
    cdq_op_e     op;

    long_hold_req   = 1'b0;
    quiet_end       = 1'b0;
    rst_n          <= 1'b0;
    in_if.valid    <= 1'b0;
    in_if.func     <= OP_PUSH_REAR;
    in_if.data_in  <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: pops on an empty deque, a push at each end with the extreme
    // words (the front push wraps the head below zero), rear pops that wrap
    // the tail, then a fill to capacity and a push at each end on a full deque.
    send_op(OP_POP_FRONT, 32'hDEAD_BEEF);
    send_op(OP_POP_REAR, 32'hFFFF_FFFF);
    send_op(OP_PUSH_REAR, 32'h7FFF_FFFF);
    send_op(OP_PUSH_FRONT, 32'h8000_0000);
    send_op(OP_POP_REAR, 32'h0000_0000);
    send_op(OP_POP_REAR, 32'h0000_0000);
    for (int unsigned k = 0; k < DEPTH; k++) begin
      send_op((k % 2 == 0) ? OP_PUSH_FRONT : OP_PUSH_REAR, pick_word(k < 4));
    end
    send_op(OP_PUSH_REAR, 32'h1357_9BDF);
    send_op(OP_PUSH_FRONT, 32'h2468_ACE0);
    drain_results();

    // Random: epochs that lean toward pushes or pops so the deque swings
    // between full and empty, with some plain noise mixed in.
    epoch_left = 0;
    push_bias  = 50;
    for (int unsigned i = 0; i < RANDOM_ITEMS; i++) begin
      if (epoch_left == 0) begin
        case ($urandom_range(0, 2))
          0:       push_bias = 15;
          1:       push_bias = 50;
          default: push_bias = 85;
        endcase
        epoch_left = $urandom_range(8, 48);
      end
      epoch_left--;

      if ($urandom_range(0, 9) == 0) begin
        op = cdq_op_e'($urandom_range(0, 3));
      end else if ($urandom_range(0, 99) < push_bias) begin
        op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_REAR;
      end else begin
        op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_REAR;
      end

      // Stall the result side for a long stretch while operations keep coming,
      // so the unit backs up and holds its input.
      if (i == HOLD_AT) begin
        long_hold_req = 1'b1;
      end
      // Stop offering until every owed result has come back.
      if (i == PAUSE_AT) begin
        drain_results();
      end
      if (i == QUIET_AT) begin
        quiet_end = 1'b1;
      end

      send_op(op, pick_word(1'b0));

      if (!quiet_end && $urandom_range(0, 5) == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
    end

    // Wait out the owed results, then keep the clock running for anything stray.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fail_cnt == 0 && owed_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== circular_deque_unit.f =====
rtl/cdq_pkg.sv
rtl/cdq_if.sv
rtl/cdq_cell.sv
rtl/circular_deque_unit.sv
test/cdq_checker.sv
test/tb_circular_deque_unit.sv
